FILE: src/awsg_pkg.sv
// Shared types, constants and cosine table function for the AM wave sample generator.
`default_nettype none

package awsg_pkg;

    // Default values for the top level parameters
    localparam int unsigned COS_TABLE_BITS_DEF = 10;
    localparam int unsigned PHASE_BITS_DEF     = 32;

    // Field widths
    localparam int unsigned STEP_W     = 32;
    localparam int unsigned AMP_W      = 15;
    localparam int unsigned GAIN_W     = 16;
    localparam int unsigned CODE_W     = 8;
    localparam int unsigned LEN_W      = 16;
    localparam int unsigned CFG_IDX_W  = 3;
    localparam int unsigned CFG_DATA_W = 32;
    localparam int unsigned MAG_W      = 15;   // quarter-wave magnitude, 0..16384
    localparam int unsigned COS_W      = 16;   // signed Q1.14 cosine

    // Configuration register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_CARRIER_STEP = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_MOD_STEP     = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_CARRIER_AMP  = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_MOD_AMP      = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_SPAN_GAIN    = 3'd4;
    localparam logic [CFG_IDX_W-1:0] CFG_MIN_CODE     = 3'd5;
    localparam logic [CFG_IDX_W-1:0] CFG_CYCLE_LENGTH = 3'd6;

    // Register reset values
    localparam logic [STEP_W-1:0] RST_CARRIER_STEP = 32'd61356676;
    localparam logic [STEP_W-1:0] RST_MOD_STEP     = 32'd6135667;
    localparam logic [AMP_W-1:0]  RST_CARRIER_AMP  = 15'd16384;
    localparam logic [AMP_W-1:0]  RST_MOD_AMP      = 15'd13107;
    localparam logic [GAIN_W-1:0] RST_SPAN_GAIN    = 16'd13156;
    localparam logic [CODE_W-1:0] RST_MIN_CODE     = 8'd70;
    localparam logic [LEN_W-1:0]  RST_CYCLE_LENGTH = 16'd700;

    // Fixed point constants
    localparam logic [63:0] TWO_PI_Q30 = 64'd6746518852;
    localparam logic [63:0] ONE_Q30    = 64'd1 << 30;
    localparam logic [63:0] HALF_Q16   = 64'd32768;
    localparam logic signed [31:0] ONE_Q28 = 32'sd268435456;
    localparam logic [CODE_W-1:0]  CODE_MAX = 8'd255;

    // Taylor series divisors (2n-1)*2n for n = 1..6
    localparam logic [63:0] TAYLOR_DIV [6] = '{64'd2, 64'd12, 64'd30, 64'd56, 64'd90, 64'd132};

    // Datapath commands from the controller
    typedef struct packed {
        logic load;     // transaction accepted, start table reads
        logic mul1;     // amplitude products
        logic mul2;     // modulation product
        logic gain;     // span gain product
        logic finish;   // write output register, advance phases
    } t_dp_cmd;

    // Datapath status to the controller
    typedef struct packed {
        logic out_free; // output register can take a new sample
    } t_dp_status;

    // Quarter-wave cosine in Q1.14, evaluated at elaboration only
    function automatic logic [MAG_W-1:0] cos_quarter(input int unsigned j,
                                                    input int unsigned tbits);
        logic [63:0]        u;
        logic [63:0]        u2;
        logic [63:0]        term;
        logic signed [63:0] sum;
        logic [63:0]        rnd;
        u    = (TWO_PI_Q30 * 64'(j)) >> tbits;
        u2   = (u * u) >> 30;
        term = ONE_Q30;
        sum  = signed'(term);
        for (int n = 1; n <= 6; n++) begin
            term = ((term * u2) >> 30) / TAYLOR_DIV[n-1];
            if ((n & 1) != 0) begin
                sum = sum - signed'(term);
            end else begin
                sum = sum + signed'(term);
            end
        end
        if (sum < 0) begin
            sum = '0;
        end
        rnd = (unsigned'(sum) + HALF_Q16) >> 16;
        return rnd[MAG_W-1:0];
    endfunction

endpackage

`default_nettype wire

FILE: src/awsg_cos_rom.sv
// Cosine lookup: quadrant folding onto a quarter-wave constant table, registered read.
`default_nettype none

module awsg_cos_rom
    import awsg_pkg::*;
#(
    parameter int unsigned COS_TABLE_BITS = COS_TABLE_BITS_DEF
) (
    input  wire logic                      i_clk,
    input  wire logic                      i_en,
    input  wire logic [COS_TABLE_BITS-1:0] i_index,
    output logic signed [COS_W-1:0]        o_cos
);

    localparam int unsigned QUARTER = 1 << (COS_TABLE_BITS - 2);
    localparam int unsigned ADDR_W  = COS_TABLE_BITS - 1;

    logic [MAG_W-1:0]  w_table [QUARTER+1];
    logic [1:0]        w_quad;
    logic [ADDR_W-2:0] w_rem;
    logic [ADDR_W-1:0] w_addr;
    logic              w_neg;
    logic [MAG_W-1:0]  w_mag;
    logic signed [COS_W-1:0] r_cos;

    // Constant quarter-wave table, one entry per point including the quarter turn
    for (genvar j = 0; j <= QUARTER; j++) begin : g_table
        assign w_table[j] = cos_quarter(j, COS_TABLE_BITS);
    end

    // Fold the phase onto the first quadrant
    assign w_quad = i_index[COS_TABLE_BITS-1 -: 2];
    assign w_rem  = i_index[COS_TABLE_BITS-3:0];
    assign w_addr = w_quad[0] ? (ADDR_W'(QUARTER) - {1'b0, w_rem}) : {1'b0, w_rem};
    assign w_neg  = w_quad[0] ^ w_quad[1];
    assign w_mag  = w_table[w_addr];

    // Registered signed read
    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_cos <= w_neg ? -$signed({1'b0, w_mag}) : $signed({1'b0, w_mag});
        end
    end

    assign o_cos = r_cos;

endmodule

`default_nettype wire

FILE: src/awsg_ctrl.sv
// Controller state machine sequencing one sample through the datapath.
`default_nettype none

module awsg_ctrl
    import awsg_pkg::*;
(
    input  wire logic       i_clk,
    input  wire logic       i_rst_n,
    input  wire logic       i_valid,
    output logic            o_ready,
    input  wire t_dp_status i_status,
    output t_dp_cmd         o_cmd
);

    localparam logic [2:0] S_IDLE = 3'd0;
    localparam logic [2:0] S_MUL1 = 3'd1;
    localparam logic [2:0] S_MUL2 = 3'd2;
    localparam logic [2:0] S_GAIN = 3'd3;
    localparam logic [2:0] S_OUT  = 3'd4;

    logic [2:0] r_state;
    logic [2:0] n_state;
    logic       w_accept;

    assign o_ready  = (r_state == S_IDLE);
    assign w_accept = i_valid && o_ready;

    // Next state
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_IDLE: if (w_accept) n_state = S_MUL1;
            S_MUL1: n_state = S_MUL2;
            S_MUL2: n_state = S_GAIN;
            S_GAIN: n_state = S_OUT;
            S_OUT:  if (i_status.out_free) n_state = S_IDLE;
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    // Datapath commands
    assign o_cmd.load   = w_accept;
    assign o_cmd.mul1   = (r_state == S_MUL1);
    assign o_cmd.mul2   = (r_state == S_MUL2);
    assign o_cmd.gain   = (r_state == S_GAIN);
    assign o_cmd.finish = (r_state == S_OUT) && i_status.out_free;

endmodule

`default_nettype wire

FILE: src/awsg_datapath.sv
// Datapath: configuration registers, phase accumulators, product chain and output register.
`default_nettype none

module awsg_datapath
    import awsg_pkg::*;
#(
    parameter int unsigned COS_TABLE_BITS = COS_TABLE_BITS_DEF,
    parameter int unsigned PHASE_BITS     = PHASE_BITS_DEF
) (
    input  wire logic                  i_clk,
    input  wire logic                  i_rst_n,
    input  wire t_dp_cmd               i_cmd,
    output t_dp_status                 o_status,
    input  wire logic                  i_restart,
    input  wire logic                  i_cfg_valid,
    input  wire logic [CFG_IDX_W-1:0]  i_cfg_index,
    input  wire logic [CFG_DATA_W-1:0] i_cfg_data,
    input  wire logic                  i_out_ready,
    output logic                       o_out_valid,
    output logic [CODE_W-1:0]          o_sample,
    output logic                       o_cycle_end
);

    // Configuration registers
    logic [STEP_W-1:0] r_carrier_step;
    logic [STEP_W-1:0] r_mod_step;
    logic [AMP_W-1:0]  r_carrier_amp;
    logic [AMP_W-1:0]  r_mod_amp;
    logic [GAIN_W-1:0] r_span_gain;
    logic [CODE_W-1:0] r_min_code;
    logic [LEN_W-1:0]  r_cycle_length;

    // Sample state
    logic [PHASE_BITS-1:0] r_carrier_phase;
    logic [PHASE_BITS-1:0] r_mod_phase;
    logic [LEN_W-1:0]      r_count;

    // Product chain
    logic [COS_TABLE_BITS-1:0] w_carrier_idx;
    logic [COS_TABLE_BITS-1:0] w_mod_idx;
    logic signed [COS_W-1:0]   w_cos_c;
    logic signed [COS_W-1:0]   w_cos_m;
    logic signed [31:0]        r_c;
    logic signed [31:0]        r_m;
    logic signed [31:0]        w_mod_bias;
    logic signed [63:0]        r_prod;
    logic [AMP_W:0]            w_amp_sum;
    logic signed [35:0]        w_s28;
    logic signed [52:0]        r_scaled;
    logic signed [18:0]        w_level;
    logic [CODE_W-1:0]         w_code;
    logic [LEN_W-1:0]          w_len_m1;
    logic                      w_last;

    // Output register
    logic              r_out_valid;
    logic [CODE_W-1:0] r_sample;
    logic              r_cycle_end;

    // Register writes
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_carrier_step <= RST_CARRIER_STEP;
            r_mod_step     <= RST_MOD_STEP;
            r_carrier_amp  <= RST_CARRIER_AMP;
            r_mod_amp      <= RST_MOD_AMP;
            r_span_gain    <= RST_SPAN_GAIN;
            r_min_code     <= RST_MIN_CODE;
            r_cycle_length <= RST_CYCLE_LENGTH;
        end else if (i_cfg_valid) begin
            unique case (i_cfg_index)
                CFG_CARRIER_STEP: r_carrier_step <= i_cfg_data[STEP_W-1:0];
                CFG_MOD_STEP:     r_mod_step     <= i_cfg_data[STEP_W-1:0];
                CFG_CARRIER_AMP:  r_carrier_amp  <= i_cfg_data[AMP_W-1:0];
                CFG_MOD_AMP:      r_mod_amp      <= i_cfg_data[AMP_W-1:0];
                CFG_SPAN_GAIN:    r_span_gain    <= i_cfg_data[GAIN_W-1:0];
                CFG_MIN_CODE:     r_min_code     <= i_cfg_data[CODE_W-1:0];
                CFG_CYCLE_LENGTH: r_cycle_length <= i_cfg_data[LEN_W-1:0];
                default: ;
            endcase
        end
    end

    // Table indexes; restart reads phase zero
    assign w_carrier_idx = i_restart ? '0 : r_carrier_phase[PHASE_BITS-1 -: COS_TABLE_BITS];
    assign w_mod_idx     = i_restart ? '0 : r_mod_phase[PHASE_BITS-1 -: COS_TABLE_BITS];

    awsg_cos_rom #(
        .COS_TABLE_BITS (COS_TABLE_BITS)
    ) u_cos_carrier (
        .i_clk   (i_clk),
        .i_en    (i_cmd.load),
        .i_index (w_carrier_idx),
        .o_cos   (w_cos_c)
    );

    awsg_cos_rom #(
        .COS_TABLE_BITS (COS_TABLE_BITS)
    ) u_cos_mod (
        .i_clk   (i_clk),
        .i_en    (i_cmd.load),
        .i_index (w_mod_idx),
        .o_cos   (w_cos_m)
    );

    // Amplitude products, Q28
    always_ff @(posedge i_clk) begin
        if (i_cmd.mul1) begin
            r_c <= $signed({1'b0, r_carrier_amp}) * w_cos_c;
            r_m <= $signed({1'b0, r_mod_amp}) * w_cos_m;
        end
    end

    // Modulation product (1 + m) * c, Q56
    assign w_mod_bias = r_m + ONE_Q28;

    always_ff @(posedge i_clk) begin
        if (i_cmd.mul2) begin
            r_prod <= 64'(w_mod_bias) * 64'(r_c);
        end
    end

    // Floor to Q28, add the (Ac + Am) offset, apply span gain (Q36)
    assign w_amp_sum = {1'b0, r_carrier_amp} + {1'b0, r_mod_amp};
    assign w_s28     = 36'(r_prod >>> 28) + $signed({5'b0, w_amp_sum, 14'b0});

    always_ff @(posedge i_clk) begin
        if (i_cmd.gain) begin
            r_scaled <= w_s28 * $signed({1'b0, r_span_gain});
        end
    end

    // Integer level plus floor code, saturated to the code range
    assign w_level = 19'(r_scaled >>> 36) + $signed({11'b0, r_min_code});

    always_comb begin
        if (w_level < 0) begin
            w_code = '0;
        end else if (w_level > $signed({11'b0, CODE_MAX})) begin
            w_code = CODE_MAX;
        end else begin
            w_code = w_level[CODE_W-1:0];
        end
    end

    // End of cycle; a length of zero behaves as one
    assign w_len_m1 = (r_cycle_length == '0) ? '0 : (r_cycle_length - LEN_W'(1));
    assign w_last   = (r_count >= w_len_m1);

    // Phase accumulators and sample counter
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_carrier_phase <= '0;
            r_mod_phase     <= '0;
            r_count         <= '0;
        end else if (i_cmd.load && i_restart) begin
            r_carrier_phase <= '0;
            r_mod_phase     <= '0;
            r_count         <= '0;
        end else if (i_cmd.finish) begin
            if (w_last) begin
                r_carrier_phase <= '0;
                r_mod_phase     <= '0;
                r_count         <= '0;
            end else begin
                r_carrier_phase <= r_carrier_phase + PHASE_BITS'(r_carrier_step);
                r_mod_phase     <= r_mod_phase + PHASE_BITS'(r_mod_step);
                r_count         <= r_count + LEN_W'(1);
            end
        end
    end

    // Output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (i_cmd.finish) begin
            r_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.finish) begin
            r_sample    <= w_code;
            r_cycle_end <= w_last;
        end
    end

    assign o_status.out_free = !r_out_valid || i_out_ready;
    assign o_out_valid       = r_out_valid;
    assign o_sample          = r_sample;
    assign o_cycle_end       = r_cycle_end;

endmodule

`default_nettype wire

FILE: src/am_wave_sample_generator.sv
// Top level of the AM wave sample generator.
`default_nettype none

// Produces one 8-bit DAC code per input transaction for an amplitude-modulated
// cosine: carrier and modulating phase accumulators index a quarter-wave cosine
// table, the value (1 + Am*cos_m)*Ac*cos_c + (Ac + Am) is scaled by span_gain,
// offset by min_code and saturated to 0..255. The table read happens on the
// accepting clock edge; the MUL1, MUL2 and GAIN states then form the amplitude
// products, the modulation product and the gain product, and the OUT state
// saturates and stores the code; the three multiplies form a dependent chain.
// One sample is in flight at a time, and the input is ready again in the cycle
// after the store, so a request is not accepted before the previous sample
// is stored. A new one is taken while the previous result still waits in
// the output register. If that register is still full when a sample
// completes, the block holds until it is taken. Asserting restart with a
// transaction zeroes both phases and the sample counter before that sample.
// cycle_end flags the last sample of each cycle of cycle_length samples. The
// configuration port is always ready and should be written only while no
// sample is in flight.
// No clearing pass follows reset.
module am_wave_sample_generator
    import awsg_pkg::*;
#(
    parameter int unsigned COS_TABLE_BITS = COS_TABLE_BITS_DEF,
    parameter int unsigned PHASE_BITS     = PHASE_BITS_DEF
) (
    input  wire logic                  i_clk,
    input  wire logic                  i_rst_n,
    // sample request channel
    input  wire logic                  i_valid,
    output logic                       o_ready,
    input  wire logic                  i_restart,
    // sample result channel
    output logic                       o_valid,
    input  wire logic                  i_ready,
    output logic [CODE_W-1:0]          o_sample,
    output logic                       o_cycle_end,
    // configuration write channel
    input  wire logic                  i_cfg_valid,
    output logic                       o_cfg_ready,
    input  wire logic [CFG_IDX_W-1:0]  i_cfg_index,
    input  wire logic [CFG_DATA_W-1:0] i_cfg_data
);

    t_dp_cmd    w_cmd;
    t_dp_status w_status;

    assign o_cfg_ready = 1'b1;

    awsg_ctrl u_ctrl (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_valid  (i_valid),
        .o_ready  (o_ready),
        .i_status (w_status),
        .o_cmd    (w_cmd)
    );

    awsg_datapath #(
        .COS_TABLE_BITS (COS_TABLE_BITS),
        .PHASE_BITS     (PHASE_BITS)
    ) u_datapath (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cmd       (w_cmd),
        .o_status    (w_status),
        .i_restart   (i_restart),
        .i_cfg_valid (i_cfg_valid && o_cfg_ready),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .i_out_ready (i_ready),
        .o_out_valid (o_valid),
        .o_sample    (o_sample),
        .o_cycle_end (o_cycle_end)
    );

endmodule

`default_nettype wire

FILE: src/awsg_checker.sv
// Port-level checks for the AM wave sample generator, bound to the top level.
`default_nettype none

module awsg_checker (
    input wire logic       i_clk,
    input wire logic       i_rst_n,
    input wire logic       i_valid,
    input wire logic       o_ready,
    input wire logic       o_valid,
    input wire logic       i_ready,
    input wire logic [7:0] o_sample,
    input wire logic       o_cycle_end
);

    // A stalled result holds its value
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && !i_ready |=> o_valid && $stable(o_sample) && $stable(o_cycle_end))
        else $error("result changed while stalled");

    // One sample in flight: no acceptance straight after an acceptance
    a_one_in_flight: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_valid && o_ready |=> !o_ready)
        else $error("second transaction accepted while a sample is in flight");

    // A fresh result follows its request transaction through the MUL1, MUL2, GAIN and OUT states
    a_latency: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(o_valid) |-> $past(i_valid && o_ready, 5))
        else $error("result without a matching request transaction");

endmodule

bind am_wave_sample_generator awsg_checker u_awsg_checker (.*);

`default_nettype wire

FILE: tb/testbench.sv
// Self-checking testbench for the AM wave sample generator, with a bit-exact code predictor.

module testbench;
    import awsg_pkg::*;

    localparam int unsigned TBL_BITS      = COS_TABLE_BITS_DEF;
    localparam int unsigned QTR           = 1 << (TBL_BITS - 2);
    localparam logic [63:0] TWO_PI_FIX    = 64'd6746518852;   // 2*pi in Q30
    localparam logic [CFG_IDX_W-1:0] CFG_NONE = 3'd7;          // unmapped index
    localparam int          IDLE_PCT      = 10;
    localparam int          HOLD_CYCLES   = 300;
    localparam int          SETTLE_CYCLES = 10;
    localparam int          DRAIN_LIMIT   = 5000;
    localparam int          ITEM_TARGET   = 500;
    localparam int          RESTART_PCT   = 5;
    localparam longint      TIMEOUT       = 4_000_000;

    typedef struct packed {
        logic [CODE_W-1:0] sample;
        logic              cycle_end;
    } t_dac_word;

    // Predicts DAC codes from accepted requests and holds them until the results arrive
    class am_code_board;
        bit [STEP_W-1:0] carrier_step;
        bit [STEP_W-1:0] mod_step;
        bit [AMP_W-1:0]  carrier_amp;
        bit [AMP_W-1:0]  mod_amp;
        bit [GAIN_W-1:0] span_gain;
        bit [CODE_W-1:0] min_code;
        bit [LEN_W-1:0]  cycle_length;
        bit [STEP_W-1:0] carrier_phase;
        bit [STEP_W-1:0] mod_phase;
        bit [LEN_W-1:0]  sample_count;
        int              quarter_cos [QTR+1];
        t_dac_word       pending_codes [$];
        int              errors;

        function new();
            for (int j = 0; j <= QTR; j++) begin
                quarter_cos[j] = taylor_cos(j);
            end
            carrier_step  = RST_CARRIER_STEP;
            mod_step      = RST_MOD_STEP;
            carrier_amp   = RST_CARRIER_AMP;
            mod_amp       = RST_MOD_AMP;
            span_gain     = RST_SPAN_GAIN;
            min_code      = RST_MIN_CODE;
            cycle_length  = RST_CYCLE_LENGTH;
            carrier_phase = '0;
            mod_phase     = '0;
            sample_count  = '0;
            errors        = 0;
        endfunction

        // Q30 Taylor series of cos, rounded half up to Q1.14
        function int taylor_cos(int unsigned j);
            logic [63:0] u;
            logic [63:0] u2;
            logic [63:0] term;
            longint      acc;
            u    = (TWO_PI_FIX * 64'(j)) >> TBL_BITS;
            u2   = (u * u) >> 30;
            term = 64'd1 << 30;
            acc  = longint'(term);
            for (int n = 1; n <= 6; n++) begin
                term = ((term * u2) >> 30) / 64'((2 * n - 1) * (2 * n));
                if (n % 2 == 1) begin
                    acc = acc - longint'(term);
                end else begin
                    acc = acc + longint'(term);
                end
            end
            if (acc < 0) begin
                acc = 0;
            end
            return int'((acc + 32768) >>> 16);
        endfunction

        // full-turn cosine by quadrant symmetry
        function int cos_at(bit [STEP_W-1:0] phase);
            bit [TBL_BITS-1:0] k;
            bit [1:0]          quad;
            int unsigned       r;
            k    = phase[STEP_W-1 -: TBL_BITS];
            quad = k[TBL_BITS-1 -: 2];
            r    = k[TBL_BITS-3:0];
            case (quad)
                2'd0:    return quarter_cos[r];
                2'd1:    return -quarter_cos[QTR - r];
                2'd2:    return -quarter_cos[r];
                default: return quarter_cos[QTR - r];
            endcase
        endfunction

        function void write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
            case (idx)
                CFG_CARRIER_STEP: carrier_step = data;
                CFG_MOD_STEP:     mod_step     = data;
                CFG_CARRIER_AMP:  carrier_amp  = data[AMP_W-1:0];
                CFG_MOD_AMP:      mod_amp      = data[AMP_W-1:0];
                CFG_SPAN_GAIN:    span_gain    = data[GAIN_W-1:0];
                CFG_MIN_CODE:     min_code     = data[CODE_W-1:0];
                CFG_CYCLE_LENGTH: cycle_length = data[LEN_W-1:0];
                default: ;
            endcase
        endfunction

        // one accepted request gives one expected code
        function void note_request(logic restart);
            longint    c;
            longint    m;
            longint    s56;
            longint    s28;
            longint    total;
            int        len;
            t_dac_word w;
            if (restart) begin
                carrier_phase = '0;
                mod_phase     = '0;
                sample_count  = '0;
            end
            c   = longint'(carrier_amp) * longint'(cos_at(carrier_phase));
            m   = longint'(mod_amp) * longint'(cos_at(mod_phase));
            s56 = ((longint'(1) << 28) + m) * c
                + ((longint'(carrier_amp) + longint'(mod_amp)) << 42);
            s28 = s56 >>> 28;
            total = s28 * longint'(span_gain) + (longint'(min_code) << 36);
            if (total < 0) begin
                w.sample = '0;
            end else if ((total >>> 36) > 255) begin
                w.sample = CODE_MAX;
            end else begin
                w.sample = CODE_W'(total >>> 36);
            end
            len = (cycle_length == 0) ? 1 : int'(cycle_length);
            w.cycle_end = (int'(sample_count) >= len - 1);
            if (w.cycle_end) begin
                carrier_phase = '0;
                mod_phase     = '0;
                sample_count  = '0;
            end else begin
                carrier_phase = carrier_phase + carrier_step;
                mod_phase     = mod_phase + mod_step;
                sample_count  = sample_count + 1'b1;
            end
            pending_codes.push_back(w);
        endfunction

        function void check_code(logic [CODE_W-1:0] sample, logic cycle_end);
            t_dac_word w;
            if (pending_codes.size() == 0) begin
                $error("unexpected result: sample %0d cycle_end %0b", sample, cycle_end);
                errors++;
                return;
            end
            w = pending_codes.pop_front();
            if (sample !== w.sample) begin
                $error("sample: expected %0d, actual %0d", w.sample, sample);
                errors++;
            end
            if (cycle_end !== w.cycle_end) begin
                $error("cycle_end: expected %0b, actual %0b", w.cycle_end, cycle_end);
                errors++;
            end
        endfunction

        function int pending();
            return pending_codes.size();
        endfunction
    endclass

    logic                  i_clk       = 1'b0;
    logic                  i_rst_n     = 1'b0;
    logic                  i_valid     = 1'b0;
    logic                  o_ready;
    logic                  i_restart   = 1'b0;
    logic                  o_valid;
    logic                  i_ready     = 1'b0;
    logic [CODE_W-1:0]     o_sample;
    logic                  o_cycle_end;
    logic                  i_cfg_valid = 1'b0;
    logic                  o_cfg_ready;
    logic [CFG_IDX_W-1:0]  i_cfg_index = '0;
    logic [CFG_DATA_W-1:0] i_cfg_data  = '0;

    am_code_board board = new();
    bit  quiet    = 1'b0;   // no idling on either side
    bit  hold_req = 1'b0;   // asks the receiver for a long hold-off
    int  items_sent = 0;

    am_wave_sample_generator i_dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_valid     (i_valid),
        .o_ready     (o_ready),
        .i_restart   (i_restart),
        .o_valid     (o_valid),
        .i_ready     (i_ready),
        .o_sample    (o_sample),
        .o_cycle_end (o_cycle_end),
        .i_cfg_valid (i_cfg_valid),
        .o_cfg_ready (o_cfg_ready),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data)
    );

    always #10 i_clk = ~i_clk;

    // Watchdog
    initial begin
        #(TIMEOUT);
        $display("testbench NOT OK");
        $finish;
    end

    // Result side: check each transaction, then choose ready for the next edge
    initial begin
        int hold_left;
        hold_left = 0;
        forever begin
            @(posedge i_clk);
            if (i_rst_n && o_valid && i_ready) begin
                board.check_code(o_sample, o_cycle_end);
            end
            if (hold_left > 0) begin
                hold_left--;
                i_ready <= 1'b0;
            end else if (hold_req) begin
                hold_req  = 1'b0;
                hold_left = HOLD_CYCLES;
                i_ready <= 1'b0;
            end else begin
                i_ready <= quiet ? 1'b1 : ($urandom_range(0, 99) >= IDLE_PCT);
            end
        end
    end

    // One request transaction, with an occasional gap in front
    task automatic send_request(input logic restart);
        if (!quiet && $urandom_range(0, 99) < IDLE_PCT) begin
            i_valid <= 1'b0;
            repeat ($urandom_range(1, 8)) @(posedge i_clk);
        end
        i_valid   <= 1'b1;
        i_restart <= restart;
        @(posedge i_clk);
        while (!o_ready) @(posedge i_clk);
        board.note_request(restart);
        items_sent++;
    endtask

    // Valid stays high between back-to-back writes; cfg_release drops it
    task automatic cfg_write(input logic [CFG_IDX_W-1:0] idx,
                             input logic [CFG_DATA_W-1:0] data);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= data;
        @(posedge i_clk);
        while (!o_cfg_ready) @(posedge i_clk);
        board.write_reg(idx, data);
    endtask

    task automatic cfg_release();
        i_cfg_valid <= 1'b0;
        @(posedge i_clk);
    endtask

    task automatic cfg_all(input logic [CFG_DATA_W-1:0] cstep, input logic [CFG_DATA_W-1:0] mstep,
                           input logic [CFG_DATA_W-1:0] camp, input logic [CFG_DATA_W-1:0] mamp,
                           input logic [CFG_DATA_W-1:0] gain, input logic [CFG_DATA_W-1:0] floor_code,
                           input logic [CFG_DATA_W-1:0] len);
        cfg_write(CFG_CARRIER_STEP, cstep);
        cfg_write(CFG_MOD_STEP, mstep);
        cfg_write(CFG_CARRIER_AMP, camp);
        cfg_write(CFG_MOD_AMP, mamp);
        cfg_write(CFG_SPAN_GAIN, gain);
        cfg_write(CFG_MIN_CODE, floor_code);
        cfg_write(CFG_CYCLE_LENGTH, len);
        cfg_release();
    endtask

    // Random settings: each register kept, set to an extreme or randomised
    task automatic random_config();
        logic [CFG_DATA_W-1:0] v;
        for (int idx = CFG_CARRIER_STEP; idx <= CFG_CYCLE_LENGTH; idx++) begin
            if ($urandom_range(0, 3) == 0) continue;
            case ($urandom_range(0, 3))
                0:       v = '1;
                1:       v = '0;
                default: v = $urandom;
            endcase
            // short cycles keep cycle ends frequent
            if (idx == CFG_CYCLE_LENGTH && v != '0 && v != '1) begin
                v = {v[CFG_DATA_W-1:LEN_W], LEN_W'($urandom_range(1, 24))};
            end
            cfg_write(CFG_IDX_W'(idx), v);
        end
        if ($urandom_range(0, 3) == 0) begin
            cfg_write(CFG_NONE, $urandom);
        end
        cfg_release();
    endtask

    // Stop offering and wait for every outstanding code, then let the block settle
    task automatic wait_drained();
        int cnt;
        cnt = 0;
        i_valid <= 1'b0;
        while (board.pending() != 0 && cnt < DRAIN_LIMIT) begin
            @(posedge i_clk);
            cnt++;
        end
        if (board.pending() != 0) begin
            $error("%0d expected results never arrived", board.pending());
            board.errors++;
        end
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    // Stimulus
    initial begin
        int phase;
        int n;
        phase = 0;
        repeat (12) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // reset settings, restart in mid-stream
        repeat (4) send_request(1'b0);
        send_request(1'b1);
        repeat (3) send_request(1'b0);
        wait_drained();

        // all-ones writes: maximum settings and masking of the upper bits
        cfg_write(CFG_NONE, '0);
        cfg_all('1, '1, '1, '1, '1, '1, '1);
        send_request(1'b0);
        send_request(1'b0);
        send_request(1'b1);
        send_request(1'b0);
        send_request(1'b0);
        wait_drained();

        // all zero, with zero cycle length acting as one
        cfg_all('0, '0, '0, '0, '0, '0, '0);
        send_request(1'b0);
        send_request(1'b1);
        send_request(1'b0);
        send_request(1'b0);
        wait_drained();

        // carrier at half a turn per sample drives the sum negative
        cfg_all(32'h8000_0000, '0, 32'h7FFF, 32'h7FFF, 32'hFFFF, '0, 32'd3);
        repeat (6) send_request(1'b0);
        send_request(1'b1);
        wait_drained();

        // random phases
        while (items_sent < ITEM_TARGET) begin
            phase++;
            random_config();
            if (phase == 2) begin
                hold_req = 1'b1;
            end
            quiet = (phase == 4);
            n = quiet ? 80 : $urandom_range(20, 50);
            repeat (n) send_request($urandom_range(0, 99) < RESTART_PCT);
            quiet = 1'b0;
            wait_drained();
        end

        if (board.errors == 0) begin
            $display("testbench OK");
        end else begin
            $display("testbench NOT OK");
        end
        $finish;
    end

endmodule

FILE: sim.f
src/awsg_pkg.sv
src/awsg_cos_rom.sv
src/awsg_ctrl.sv
src/awsg_datapath.sv
src/am_wave_sample_generator.sv
src/awsg_checker.sv
tb/testbench.sv
